>>> rtl/psw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types, constants and the header signature table of the section walker.
// ----------------------------------------------------------------------------
package psw_pkg;

  localparam int unsigned MAGIC_LEN   = 24;
  localparam int unsigned SEC_HDR_LEN = 12;
  localparam int unsigned SEC_MIN_LEN = 16;

  localparam logic [31:0] END_NAME_LO = 32'h656E_6400;  // "end" and NUL
  localparam logic [31:0] END_NAME_UP = 32'h454E_4400;  // "END" and NUL

  localparam logic [1:0] KIND_REG      = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_BADMAGIC = 2'd2;
  localparam logic [1:0] KIND_INVALID  = 2'd3;

  localparam logic [1:0] CFG_PACK_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_MATCH_MASK  = 2'd1;
  localparam logic [1:0] CFG_MATCH_VALUE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sec_offset;
    logic [31:0] sec_length;
    logic [31:0] data_offset;
    logic [31:0] data_length;
    logic [31:0] sec_flags;
    logic        flags_match;
    logic [31:0] total_size;
    logic        last;
  } res_t;

  // Results produced by one byte: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [31:0] soff,
                                  input logic [31:0] slen, input logic [31:0] doff,
                                  input logic [31:0] dlen, input logic [31:0] flags,
                                  input logic match, input logic [31:0] total);
    res_t r;
    r.kind        = kind;
    r.sec_offset  = soff;
    r.sec_length  = slen;
    r.data_offset = doff;
    r.data_length = dlen;
    r.sec_flags   = flags;
    r.flags_match = match;
    r.total_size  = total;
    r.last        = 1'b0;
    return r;
  endfunction

  // Fixed image signature, one byte per address.
  function automatic logic [7:0] magic_byte(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:    v = 8'h23;
      5'd1:    v = 8'h21;
      5'd2:    v = 8'h2f;
      5'd3:    v = 8'h75;
      5'd4:    v = 8'h73;
      5'd5:    v = 8'h72;
      5'd6:    v = 8'h2f;
      5'd7:    v = 8'h62;
      5'd8:    v = 8'h69;
      5'd9:    v = 8'h6e;
      5'd10:   v = 8'h2f;
      5'd11:   v = 8'h65;
      5'd12:   v = 8'h6e;
      5'd13:   v = 8'h76;
      5'd14:   v = 8'h20;
      5'd15:   v = 8'h41;
      5'd16:   v = 8'h74;
      5'd17:   v = 8'h6f;
      5'd18:   v = 8'h6d;
      5'd19:   v = 8'h56;
      5'd20:   v = 8'h4d;
      5'd21:   v = 8'h0a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/psw_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psw_walker
// Input register, configuration registers and the per-byte parse logic.
// ----------------------------------------------------------------------------
module psw_walker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_sop,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic              room,
  output psw_pkg::push_t         push
);
  import psw_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_MAGIC   = 3'd1;
  localparam logic [2:0] PH_HDR     = 3'd2;
  localparam logic [2:0] PH_NAME    = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;
  localparam logic [2:0] PH_ENDNAME = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  logic        inp_vld_r;
  logic [7:0]  inp_byte_r;
  logic        inp_sop_r;
  logic        fire;

  logic [31:0] limit_r, mask_r, value_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] flags_r, flags_nxt;
  logic [31:0] head_r, head_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] end_r, end_nxt;   // section start plus section size

  assign fire     = inp_vld_r & room;
  assign in_ready = ~inp_vld_r | room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_vld_r <= 1'b0;
    end else if (in_ready) begin
      inp_vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      inp_byte_r <= in_byte;
      inp_sop_r  <= in_sop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 32'hFFFF_FFFF;
      mask_r  <= '0;
      value_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PACK_LIMIT:  limit_r <= cfg_wdata;
        CFG_MATCH_MASK:  mask_r  <= cfg_wdata;
        CFG_MATCH_VALUE: value_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [2:0]  ph;
  logic [31:0] p, s, sz, fl, hd, nc, rel, sz_new, hd_new, region, bs_off, room_diff;
  logic [32:0] pad_sum, padded, bs_diff;
  logic        bs_go, bs_noroom;
  logic [1:0]  n;
  res_t        r0, r1, bs_res;

  always_comb begin
    ph = phase_r;
    p  = pos_r;
    s  = start_r;
    sz = size_r;
    fl = flags_r;
    hd = head_r;
    nc = cnt_r;
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    bs_go = 1'b0;

    if (inp_sop_r) begin
      ph = PH_MAGIC;
      p  = '0;
      s  = '0;
      sz = '0;
      fl = '0;
      hd = '0;
      nc = '0;
      if (limit_r < 32'(MAGIC_LEN)) begin
        r0 = mk_res(KIND_BADMAGIC, '0, '0, '0, '0, '0, 1'b0, '0);
        n  = 2'd1;
        ph = PH_DONE;
      end
    end

    pos_nxt   = p + 32'd1;
    rel       = p - s;
    phase_nxt = ph;
    start_nxt = s;
    size_nxt  = sz;
    flags_nxt = fl;
    head_nxt  = hd;
    cnt_nxt   = nc;
    end_nxt   = end_r;

    sz_new  = {sz[23:0], inp_byte_r};
    hd_new  = {hd[23:0], inp_byte_r};
    region  = sz - 32'(SEC_HDR_LEN);
    pad_sum = {1'b0, nc} + 33'd4;
    padded  = {pad_sum[32:2], 2'b00};
    room_diff = limit_r - s;

    // Room check for the section that would start next.
    bs_off    = (ph == PH_MAGIC) ? 32'(MAGIC_LEN) : end_r;
    bs_diff   = {1'b0, limit_r} - {1'b0, bs_off};
    bs_noroom = bs_diff[32] | (bs_diff[31:0] < 32'(SEC_MIN_LEN));
    bs_res    = mk_res(KIND_INVALID, bs_off, '0, '0, '0, '0, 1'b0, '0);

    unique case (ph)
      PH_MAGIC: begin
        if (p >= 32'(MAGIC_LEN) || inp_byte_r != magic_byte(p[4:0])) begin
          r0 = mk_res(KIND_BADMAGIC, '0, '0, '0, '0, '0, 1'b0, '0);
          n  = 2'd1;
          phase_nxt = PH_DONE;
        end else if (p == 32'(MAGIC_LEN - 1)) begin
          bs_go = 1'b1;
        end
      end
      PH_HDR: begin
        if (rel < 32'd4) begin
          size_nxt = sz_new;
          if (rel == 32'd3 && sz_new != '0 &&
              (sz_new < 32'(SEC_MIN_LEN) || sz_new[1:0] != 2'b00 || sz_new > room_diff)) begin
            r0 = mk_res(KIND_INVALID, s, sz_new, '0, '0, '0, 1'b0, '0);
            n  = 2'd1;
            phase_nxt = PH_DONE;
          end
        end else if (rel < 32'd8) begin
          flags_nxt = {fl[23:0], inp_byte_r};
          end_nxt   = s + sz;
        end else if (rel == 32'd11) begin
          phase_nxt = (sz == '0) ? PH_ENDNAME : PH_NAME;
        end
      end
      PH_ENDNAME: begin
        head_nxt = hd_new;
        if (rel >= 32'd15) begin
          n = 2'd1;
          phase_nxt = PH_DONE;
          if (fl == '0 && (hd_new == END_NAME_LO || hd_new == END_NAME_UP)) begin
            r0 = mk_res(KIND_END, s, '0, s + 32'(SEC_MIN_LEN), '0, '0,
                        value_r == '0, s + 32'(SEC_MIN_LEN));
          end else begin
            r0 = mk_res(KIND_INVALID, s, '0, '0, '0, '0, 1'b0, '0);
          end
        end
      end
      PH_NAME: begin
        if (inp_byte_r == 8'h00) begin
          n = 2'd1;
          if (padded > {1'b0, region}) begin
            r0 = mk_res(KIND_INVALID, s, sz, '0, '0, '0, 1'b0, '0);
            phase_nxt = PH_DONE;
          end else begin
            r0 = mk_res(KIND_REG, s, sz, s + 32'(SEC_HDR_LEN) + padded[31:0],
                        region - padded[31:0], fl, (fl & mask_r) == value_r, '0);
            if (pos_nxt == end_r) begin
              bs_go = 1'b1;
            end else if (bs_noroom) begin
              r1 = bs_res;
              n  = 2'd2;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end else begin
          cnt_nxt = nc + 32'd1;
          if (pos_nxt == end_r) begin
            r0 = mk_res(KIND_INVALID, s, sz, '0, '0, '0, 1'b0, '0);
            n  = 2'd1;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_SKIP: begin
        if (pos_nxt == end_r) begin
          bs_go = 1'b1;
        end
      end
      default: ;
    endcase

    if (bs_go) begin
      start_nxt = bs_off;
      size_nxt  = '0;
      flags_nxt = '0;
      head_nxt  = '0;
      cnt_nxt   = '0;
      if (bs_noroom) begin
        phase_nxt = PH_DONE;
        if (n == 2'd0) begin
          r0 = bs_res;
          n  = 2'd1;
        end else begin
          r1 = bs_res;
          n  = 2'd2;
        end
      end else begin
        phase_nxt = PH_HDR;
      end
    end

    r0.last = (n == 2'd1);
    r1.last = 1'b1;

    push.count = fire ? n : 2'd0;
    push.r0    = r0;
    push.r1    = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      size_r  <= '0;
      flags_r <= '0;
      head_r  <= '0;
      cnt_r   <= '0;
      end_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      size_r  <= size_nxt;
      flags_r <= flags_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/psw_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psw_out_fifo
// Four-entry result queue that takes up to two results per cycle.
// ----------------------------------------------------------------------------
module psw_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  psw_pkg::push_t        push,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output psw_pkg::res_t         out_res
);
  import psw_pkg::*;

  res_t       mem [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = mem[rd_ptr_r];
  assign pop       = out_valid & out_ready;
  // Two free entries are needed since one byte can yield two results.
  assign room      = (cnt_r <= 3'd2);
  assign cnt_nxt   = cnt_r + {1'b0, push.count} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push.count;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pack_section_walker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pack_section_walker_core
// Byte-serial walker over a section archive image, reporting each section.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | handshake
//  in_      | in  | tdata byte, tuser start of image          | tvalid/tready
//  out_     | out | tdata section report, tlast last of byte  | tvalid/tready
//  cfg_     | in  | index 0 limit, 1 mask, 2 value            | wr_en only
//
// One byte is accepted per cycle while in_tready is high; it is parsed from the
// input register and its results reach out_ through the result queue. A byte
// yields at most two results; in_tready drops only when the input register is
// full and the four-entry result queue has fewer than two free entries. Reset is
// synchronous; after it the walker ignores bytes until one marks a new image.
// ----------------------------------------------------------------------------
module pack_section_walker_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] byte_value
  input  wire logic         in_tuser,   // [0] start_of_pack
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [199:0]      out_tdata,  // [1:0] section_kind, [33:2] section_offset,
                                        // [65:34] section_length, [97:66] data_offset,
                                        // [129:98] data_length, [161:130] section_flags,
                                        // [162] flags_match, [194:163] total_size
  output logic              out_tlast,  // last_of_step
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  import psw_pkg::*;

  push_t push;
  res_t  res;
  logic  room;

  psw_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_sop    (in_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .room      (room),
    .push      (push)
  );

  psw_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {5'b00000, res.total_size, res.flags_match, res.sec_flags,
                      res.data_length, res.data_offset, res.sec_length,
                      res.sec_offset, res.kind};
  assign out_tlast = res.last;

endmodule
`default_nettype wire
